@@ sv/vpt_pkg.sv @@
// shared types and constants for the voice priority table
package vpt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ID_W        = 8;
	localparam int PRIO_W      = 10;
	localparam int OCC_W       = 5;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_REMOVE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic              cmp_en;
		logic              upd_en;
		kind_t             kind;
		logic              full;
		logic              ge_any;
		logic [ID_W-1:0]   req_id;
		logic [PRIO_W-1:0] req_prio;
	} cell_ctrl_t;

endpackage

@@ sv/vpt_cell.sv @@
// one table slot: compares against the request and shifts with its neighbors
module vpt_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 5
) (
	input  logic                          clk,
	input  vpt_pkg::cell_ctrl_t           ctrl,
	input  logic [CNT_W-1:0]              count,
	input  logic [vpt_pkg::ID_W-1:0]      left_id,
	input  logic [vpt_pkg::PRIO_W-1:0]    left_prio,
	input  logic [vpt_pkg::ID_W-1:0]      right_id,
	input  logic [vpt_pkg::PRIO_W-1:0]    right_prio,
	input  logic                          ge_before_in,
	input  logic                          match_before_in,
	input  logic [vpt_pkg::ID_W-1:0]      ev_id_in,
	output logic [vpt_pkg::ID_W-1:0]      id,
	output logic [vpt_pkg::PRIO_W-1:0]    prio,
	output logic                          ge_before_out,
	output logic                          match_before_out,
	output logic [vpt_pkg::ID_W-1:0]      ev_id_out
);

	logic [vpt_pkg::ID_W-1:0]   id_q;
	logic [vpt_pkg::PRIO_W-1:0] prio_q;
	logic                       ge_q;
	logic                       match_q;
	logic                       slot_valid;
	logic                       first_ge;
	logic                       match_incl;
	logic                       append_here;

	assign slot_valid  = count > CNT_W'(INDEX);
	assign first_ge    = ge_q && !ge_before_in;
	assign match_incl  = match_before_in || match_q;
	assign append_here = !ctrl.ge_any && (count == CNT_W'(INDEX));

	assign ge_before_out    = ge_before_in || ge_q;
	assign match_before_out = match_incl;
	assign ev_id_out        = ev_id_in | (first_ge ? id_q : '0);
	assign id               = id_q;
	assign prio             = prio_q;

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			ge_q    <= slot_valid && (prio_q >= ctrl.req_prio);
			match_q <= slot_valid && (id_q == ctrl.req_id);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.upd_en) begin
			case (ctrl.kind)
				vpt_pkg::KIND_INSERT: begin
					if (!ctrl.full) begin
						if (first_ge || append_here) begin
							id_q   <= ctrl.req_id;
							prio_q <= ctrl.req_prio;
						end else if (ge_before_in) begin
							id_q   <= left_id;
							prio_q <= left_prio;
						end
					end else if (first_ge) begin
						id_q   <= ctrl.req_id;
						prio_q <= ctrl.req_prio;
					end
				end
				vpt_pkg::KIND_REMOVE: begin
					if (match_incl) begin
						id_q   <= right_id;
						prio_q <= right_prio;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ sv/voice_priority_table_unit.sv @@
// voice priority table: sorted row of slot cells with insert, evict and remove
// Each operation runs in two states: in the compare state every slot cell registers its compare
// against the request; in the update state the first-hit flag ripples along the cell row and
// every slot loads the request, its left or its right neighbor's entry, or keeps its own. The
// next beat is taken in the update state while the output register is free. The result beat
// waits in an output register; while it is stalled an operation in its update state holds. The
// table has no clearing pass: its slot entries are not reset, only the occupancy count.
module voice_priority_table_unit #(
	parameter int TABLE_DEPTH = vpt_pkg::TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [vpt_pkg::ID_W-1:0]      voice_id,
	input  logic [vpt_pkg::PRIO_W-1:0]    priority_req,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          accepted,
	output logic                          evicted_valid,
	output logic [vpt_pkg::ID_W-1:0]      evicted_id,
	output logic [vpt_pkg::OCC_W-1:0]     occupancy
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	vpt_pkg::state_t            state_q, state_d;
	vpt_pkg::kind_t             kind_q;
	logic [vpt_pkg::ID_W-1:0]   id_q;
	logic [vpt_pkg::PRIO_W-1:0] prio_q;
	logic [CNT_W-1:0]           count_q, count_d;
	logic                       out_valid_q;
	logic                       accepted_q;
	logic                       evicted_valid_q;
	logic [vpt_pkg::ID_W-1:0]   evicted_id_q;
	logic [vpt_pkg::OCC_W-1:0]  occupancy_q;

	logic                       in_fire;
	logic                       out_free;
	logic                       upd_fire;
	logic                       full;
	logic                       res_accepted;
	logic                       res_evicted;
	vpt_pkg::cell_ctrl_t        ctrl;

	logic [vpt_pkg::ID_W-1:0]   cell_id   [TABLE_DEPTH];
	logic [vpt_pkg::PRIO_W-1:0] cell_prio [TABLE_DEPTH];
	logic [TABLE_DEPTH:0]       ge_chain;
	logic [TABLE_DEPTH:0]       match_chain;
	logic [vpt_pkg::ID_W-1:0]   ev_chain  [TABLE_DEPTH+1];

	assign out_free = !out_valid_q || !out_stall;
	assign upd_fire = (state_q == vpt_pkg::ST_UPD) && out_free;
	assign in_stall = !((state_q == vpt_pkg::ST_IDLE) || upd_fire);
	assign in_fire  = in_valid && !in_stall;
	assign full     = count_q == CNT_W'(TABLE_DEPTH);

	assign ctrl.cmp_en   = state_q == vpt_pkg::ST_CMP;
	assign ctrl.upd_en   = upd_fire;
	assign ctrl.kind     = kind_q;
	assign ctrl.full     = full;
	assign ctrl.ge_any   = ge_chain[TABLE_DEPTH];
	assign ctrl.req_id   = id_q;
	assign ctrl.req_prio = prio_q;

	assign ge_chain[0]    = 1'b0;
	assign match_chain[0] = 1'b0;
	assign ev_chain[0]    = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		localparam int LEFT  = (i == 0) ? 0 : i - 1;
		localparam int RIGHT = (i == TABLE_DEPTH - 1) ? i : i + 1;
		vpt_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk              (clk),
			.ctrl             (ctrl),
			.count            (count_q),
			.left_id          (cell_id[LEFT]),
			.left_prio        (cell_prio[LEFT]),
			.right_id         (cell_id[RIGHT]),
			.right_prio       (cell_prio[RIGHT]),
			.ge_before_in     (ge_chain[i]),
			.match_before_in  (match_chain[i]),
			.ev_id_in         (ev_chain[i]),
			.id               (cell_id[i]),
			.prio             (cell_prio[i]),
			.ge_before_out    (ge_chain[i+1]),
			.match_before_out (match_chain[i+1]),
			.ev_id_out        (ev_chain[i+1])
		);
	end

	always_comb begin
		res_accepted = 1'b0;
		res_evicted  = 1'b0;
		count_d      = count_q;
		case (kind_q)
			vpt_pkg::KIND_INSERT: begin
				if (!full) begin
					res_accepted = 1'b1;
					count_d      = count_q + CNT_W'(1);
				end else if (ge_chain[TABLE_DEPTH]) begin
					res_accepted = 1'b1;
					res_evicted  = 1'b1;
				end
			end
			vpt_pkg::KIND_REMOVE: begin
				if (match_chain[TABLE_DEPTH]) begin
					res_accepted = 1'b1;
					count_d      = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			vpt_pkg::ST_IDLE: if (in_fire) state_d = vpt_pkg::ST_CMP;
			vpt_pkg::ST_CMP:  state_d = vpt_pkg::ST_UPD;
			vpt_pkg::ST_UPD: begin
				if (upd_fire) begin
					state_d = in_fire ? vpt_pkg::ST_CMP : vpt_pkg::ST_IDLE;
				end
			end
			default: state_d = vpt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vpt_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (upd_fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= vpt_pkg::kind_t'(kind);
			id_q   <= voice_id;
			prio_q <= priority_req;
		end
		if (upd_fire) begin
			accepted_q      <= res_accepted;
			evicted_valid_q <= res_evicted;
			evicted_id_q    <= res_evicted ? ev_chain[TABLE_DEPTH] : '0;
			occupancy_q     <= vpt_pkg::OCC_W'(count_d);
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_id    = evicted_id_q;
	assign occupancy     = occupancy_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("occupancy count above table depth");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && evicted_valid_q |-> accepted_q && (occupancy_q == vpt_pkg::OCC_W'(TABLE_DEPTH)))
		else $error("eviction reported with table not full");

	a_refused_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire && !res_accepted |=> $stable(count_q))
		else $error("refused beat changed the count");

	a_one_op_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vpt_pkg::ST_CMP) |-> in_stall)
		else $error("beat taken during compare cycle");

endmodule

@@ tb/sv/voice_priority_table_check.sv @@
// beat monitor, voice table predictor and result comparison for the voice priority table
module voice_priority_table_check
	import vpt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              kind,
	input  logic [ID_W-1:0]   voice_id,
	input  logic [PRIO_W-1:0] priority_req,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              accepted,
	input  logic              evicted_valid,
	input  logic [ID_W-1:0]   evicted_id,
	input  logic [OCC_W-1:0]  occupancy,
	output int                mismatch_count,
	output int                pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic              accepted;
		logic              evicted_valid;
		logic [ID_W-1:0]   evicted_id;
		logic [OCC_W-1:0]  occupancy;
	} table_outcome_t;

	logic [ID_W-1:0]   voice_ids [TABLE_DEPTH];
	logic [PRIO_W-1:0] voice_prios [TABLE_DEPTH];
	int                voice_total;
	table_outcome_t    expected_outcomes [$];

	function automatic table_outcome_t place_or_remove_voice(kind_t op, logic [ID_W-1:0] id,
			logic [PRIO_W-1:0] prio);
		table_outcome_t r;
		int slot;
		r = '0;
		slot = -1;
		if (op == KIND_INSERT) begin
			for (int i = voice_total - 1; i >= 0; i--)
				if (voice_prios[i] >= prio)
					slot = i;
			if (slot >= 0 && voice_total < TABLE_DEPTH) begin
				for (int i = voice_total; i > slot; i--) begin
					voice_ids[i] = voice_ids[i-1];
					voice_prios[i] = voice_prios[i-1];
				end
				voice_ids[slot] = id;
				voice_prios[slot] = prio;
				voice_total++;
				r.accepted = 1'b1;
			end else if (slot >= 0) begin
				r.evicted_valid = 1'b1;
				r.evicted_id = voice_ids[slot];
				voice_ids[slot] = id;
				voice_prios[slot] = prio;
				r.accepted = 1'b1;
			end else if (voice_total < TABLE_DEPTH) begin
				voice_ids[voice_total] = id;
				voice_prios[voice_total] = prio;
				voice_total++;
				r.accepted = 1'b1;
			end
		end else begin
			for (int i = voice_total - 1; i >= 0; i--)
				if (voice_ids[i] == id)
					slot = i;
			if (slot >= 0) begin
				for (int i = slot; i < voice_total - 1; i++) begin
					voice_ids[i] = voice_ids[i+1];
					voice_prios[i] = voice_prios[i+1];
				end
				voice_total--;
				r.accepted = 1'b1;
			end
		end
		r.occupancy = voice_total[OCC_W-1:0];
		return r;
	endfunction

	// inputs and outputs only move at the rising edge, so the falling edge sees settled beats
	always @(negedge clk or negedge arst_n) begin
		table_outcome_t want;
		if (!arst_n) begin
			voice_total = 0;
			expected_outcomes.delete();
			pending_results = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_outcomes.size() == 0) begin
					$error("result beat with no expected result waiting");
					mismatch_count++;
				end else begin
					want = expected_outcomes.pop_front();
					if (accepted !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted, accepted);
						mismatch_count++;
					end
					if (evicted_valid !== want.evicted_valid) begin
						$error("evicted_valid: expected %0d, got %0d", want.evicted_valid,
							evicted_valid);
						mismatch_count++;
					end
					if (evicted_id !== want.evicted_id) begin
						$error("evicted_id: expected %0d, got %0d", want.evicted_id, evicted_id);
						mismatch_count++;
					end
					if (occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_outcomes.push_back(place_or_remove_voice(kind_t'(kind), voice_id,
					priority_req));
			pending_results = expected_outcomes.size();
		end
	end

endmodule

@@ tb/sv/voice_priority_table_unit_test.sv @@
// stimulus, idling phases and verdict for the voice priority table testbench
module voice_priority_table_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import vpt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 120;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              kind = KIND_INSERT;
	logic [ID_W-1:0]   voice_id = '0;
	logic [PRIO_W-1:0] priority_req = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              accepted;
	logic              evicted_valid;
	logic [ID_W-1:0]   evicted_id;
	logic [OCC_W-1:0]  occupancy;

	int          mismatch_count;
	int          pending_results;
	int          cycle_count = 0;
	int          hold_count = 0;
	logic        long_hold = 1'b0;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;

	voice_priority_table_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.voice_id      (voice_id),
		.priority_req  (priority_req),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.accepted      (accepted),
		.evicted_valid (evicted_valid),
		.evicted_id    (evicted_id),
		.occupancy     (occupancy)
	);

	voice_priority_table_check check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.voice_id        (voice_id),
		.priority_req    (priority_req),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.accepted        (accepted),
		.evicted_valid   (evicted_valid),
		.evicted_id      (evicted_id),
		.occupancy       (occupancy),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: random stalls, or one long hold-off while long_hold is up
	always @(posedge clk) begin
		if (long_hold && hold_count < HOLD_CYCLES) begin
			out_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			out_stall <= stall_pct != 0 && $urandom_range(99) < stall_pct;
			if (!long_hold)
				hold_count <= 0;
		end
	end

	task automatic send_beat(input kind_t op, input logic [ID_W-1:0] id,
			input logic [PRIO_W-1:0] prio);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		voice_id <= id;
		priority_req <= prio;
		@(negedge clk);
		while (in_stall) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	task automatic send_random(input int count);
		kind_t             op;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		int                insert_pct;
		for (int n = 0; n < count; n++) begin
			// alternate fill-heavy and drain-heavy stretches so the table sweeps empty to full
			insert_pct = ((n / 16) % 2 == 0) ? 80 : 30;
			op = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
			id = ($urandom_range(9) == 0) ? ID_W'($urandom_range(255)) : ID_W'($urandom_range(23));
			case ($urandom_range(3))
				0: prio = PRIO_W'($urandom_range(7));
				1: prio = ($urandom_range(1) == 0) ? PRIO_W'(0) : PRIO_W'(1023);
				default: prio = PRIO_W'($urandom_range(1023));
			endcase
			send_beat(op, id, prio);
		end
	endtask

	task automatic drain_results;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, append, ties, duplicate ids, absent remove
		send_beat(KIND_REMOVE, 8'h12, 10'd0);
		send_beat(KIND_INSERT, 8'h00, 10'd0);
		send_beat(KIND_INSERT, 8'hff, 10'd1000);
		send_beat(KIND_INSERT, 8'h55, 10'd512);
		send_beat(KIND_INSERT, 8'haa, 10'd512);
		send_beat(KIND_INSERT, 8'h55, 10'd100);
		send_beat(KIND_REMOVE, 8'h55, 10'd1023);
		send_beat(KIND_REMOVE, 8'h77, 10'd0);
		for (int i = 0; i < 12; i++)
			send_beat(KIND_INSERT, ID_W'(8'h10 + i), PRIO_W'(200 + 50 * i));
		// full table: refused, evict at the tail, evict at the head, then removes
		send_beat(KIND_INSERT, 8'h33, 10'd1023);
		send_beat(KIND_INSERT, 8'hcc, 10'd1000);
		send_beat(KIND_INSERT, 8'h99, 10'd0);
		send_beat(KIND_REMOVE, 8'hcc, 10'd0);
		send_beat(KIND_REMOVE, 8'haa, 10'd0);
		drain_results();

		send_random(PHASE_ITEMS);
		drain_results();
		idle_pct <= 69;
		send_random(PHASE_ITEMS);
		drain_results();
		idle_pct <= 0;
		stall_pct <= 69;
		send_random(PHASE_ITEMS);
		drain_results();
		idle_pct <= 23;
		stall_pct <= 23;
		send_random(PHASE_ITEMS);
		drain_results();

		idle_pct <= 0;
		stall_pct <= 0;
		long_hold <= 1'b1;
		send_random(30);
		long_hold <= 1'b0;
		drain_results();

		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
